FILE: sv/stereo_tilt_equalizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo tilt equalizer
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef STEREO_TILT_EQUALIZER_MACROS_SVH
`define STEREO_TILT_EQUALIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/stqe_pkg.sv
// ----------------------------------------------------------------------------
// Stereo tilt equalizer package
// Shared widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package stqe_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 16;

  localparam int GAIN_BITS   = 18;
  localparam int GAIN_FRAC   = 16;
  localparam int GLIDE_EXTRA = 22;
  localparam int GLIDE_BITS  = GAIN_BITS + GLIDE_EXTRA;
  localparam int ALPHA_BITS  = 24;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PIVOT       = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_LOW  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_HIGH = 2'd3;

  localparam int PIVOT_RESET = 4030;
  localparam logic [ALPHA_BITS-1:0] SMOOTHING_RESET = 24'd17466;
  localparam logic [GAIN_BITS-1:0]  TARGET_RESET    = 18'd65536;
  localparam logic [GLIDE_BITS-1:0] GAIN_NOW_RESET  = 40'd1 << (GAIN_FRAC + GLIDE_EXTRA);

endpackage

FILE: sv/stqe_glide.sv
// ----------------------------------------------------------------------------
// Gain glide unit
// Moves one gain one smoothing step toward its target with a bit-serial
// shift-and-add multiplier, one bit of the glide factor per cycle.
// ----------------------------------------------------------------------------
module stqe_glide (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [stqe_pkg::ALPHA_BITS-1:0]  alpha,
  input  logic [stqe_pkg::GAIN_BITS-1:0]   target,
  output logic                             done,
  output logic [stqe_pkg::GAIN_BITS-1:0]   gain
);
  import stqe_pkg::*;

  localparam int CW = $clog2(ALPHA_BITS);

  localparam logic [1:0] G_IDLE  = 2'd0;
  localparam logic [1:0] G_RUN   = 2'd1;
  localparam logic [1:0] G_APPLY = 2'd2;

  logic [1:0]            state;
  logic [CW-1:0]         cnt;
  logic [GLIDE_BITS-1:0] now;
  logic [GLIDE_BITS-1:0] delta;
  logic [GLIDE_BITS-1:0] acc;
  logic [ALPHA_BITS-1:0] mult;
  logic                  up;
  logic [GLIDE_BITS-1:0] goal;
  logic [GLIDE_BITS:0]   sum;

  assign goal = {target, {GLIDE_EXTRA{1'b0}}};
  assign sum  = {1'b0, acc} + (mult[0] ? {1'b0, delta} : '0);
  assign gain = now[GLIDE_BITS-1:GLIDE_EXTRA];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      cnt   <= '0;
      now   <= GAIN_NOW_RESET;
      done  <= 1'b0;
    end else begin
      done <= (state == G_APPLY);
      unique case (state)
        G_IDLE: begin
          if (start) begin
            up    <= (goal >= now);
            delta <= (goal >= now) ? goal - now : now - goal;
            acc   <= '0;
            mult  <= alpha;
            cnt   <= '0;
            state <= G_RUN;
          end
        end
        G_RUN: begin
          acc  <= sum[GLIDE_BITS:1];
          mult <= mult >> 1;
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(ALPHA_BITS - 1)) begin
            state <= G_APPLY;
          end
        end
        G_APPLY: begin
          now   <= up ? now + acc : now - acc;
          state <= G_IDLE;
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/stqe_chan.sv
// ----------------------------------------------------------------------------
// Channel lane
// One-pole trapezoidal split and gain mix for one channel, both products
// formed bit-serially, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module stqe_chan #(
  parameter int SB = stqe_pkg::SAMPLE_BITS_DEF,
  parameter int CB = stqe_pkg::COEF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [SB-1:0]            x,
  input  logic [CB-1:0]                   g,
  input  logic [stqe_pkg::GAIN_BITS-1:0]  low_gain,
  input  logic [stqe_pkg::GAIN_BITS-1:0]  high_gain,
  output logic                            done,
  output logic signed [SB-1:0]            y
);
  import stqe_pkg::*;

  localparam int SW = SB + 4;
  localparam int EW = SW + 1;
  localparam int LW = SW + 2;
  localparam int DW = SW + 4;
  localparam int YW = DW + GAIN_BITS - GAIN_FRAC;
  localparam int CNT_MAX = (CB > GAIN_BITS) ? CB : GAIN_BITS;
  localparam int CW = $clog2(CNT_MAX);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_FILT = 3'd1;
  localparam logic [2:0] C_UPD  = 3'd2;
  localparam logic [2:0] C_DOT  = 3'd3;
  localparam logic [2:0] C_SAT  = 3'd4;

  logic [2:0]           state;
  logic [CW-1:0]        cnt;
  logic [SW-1:0]        s;
  logic [EW-1:0]        e;
  logic [EW-1:0]        hf;
  logic [CB-1:0]        gm;
  logic [LW-1:0]        lp;
  logic [LW:0]          d2;
  logic [DW-1:0]        hd;
  logic [GAIN_BITS-1:0] ld;
  logic [GAIN_BITS-1:0] lo_sh;
  logic [GAIN_BITS-1:0] hi_sh;

  logic [EW-1:0] e_next;
  logic [EW:0]   fsum;
  logic [LW-1:0] lp_next;
  logic [LW:0]   s2;
  logic [SW-1:0] s_next;
  logic [LW:0]   d2_next;
  logic [DW:0]   dsum;
  logic [YW-1:0] yfull;
  logic [SB-1:0] y_next;

  assign e_next  = {{(EW-SB){x[SB-1]}}, x} - {s[SW-1], s};
  assign fsum    = {hf[EW-1], hf} + (gm[0] ? {e[EW-1], e} : '0);
  assign lp_next = {{2{s[SW-1]}}, s} + {hf[EW-1], hf};
  assign s2      = {{3{s[SW-1]}}, s} + {{2{hf[EW-1]}}, hf} + {{2{hf[EW-1]}}, hf};
  assign d2_next = {{(LW+1-SB){x[SB-1]}}, x} - {lp_next[LW-1], lp_next};
  assign dsum    = {hd[DW-1], hd}
                 + (lo_sh[0] ? {{3{lp[LW-1]}}, lp} : '0)
                 + (hi_sh[0] ? {{2{d2[LW]}}, d2} : '0);
  assign yfull   = {hd, ld[GAIN_BITS-1:GAIN_FRAC]};

  always_comb begin
    if ((&s2[LW:SW-1]) || !(|s2[LW:SW-1])) begin
      s_next = s2[SW-1:0];
    end else if (s2[LW]) begin
      s_next = {1'b1, {(SW-1){1'b0}}};
    end else begin
      s_next = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_comb begin
    if ((&yfull[YW-1:SB-1]) || !(|yfull[YW-1:SB-1])) begin
      y_next = yfull[SB-1:0];
    end else if (yfull[YW-1]) begin
      y_next = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_next = {1'b0, {(SB-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
      s     <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == C_SAT);
      unique case (state)
        C_IDLE: begin
          if (start) begin
            e     <= e_next;
            hf    <= '0;
            gm    <= g;
            cnt   <= '0;
            state <= C_FILT;
          end
        end
        C_FILT: begin
          hf  <= fsum[EW:1];
          gm  <= gm >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(CB - 1)) begin
            state <= C_UPD;
          end
        end
        C_UPD: begin
          lp    <= lp_next;
          d2    <= d2_next;
          s     <= s_next;
          hd    <= '0;
          lo_sh <= low_gain;
          hi_sh <= high_gain;
          cnt   <= '0;
          state <= C_DOT;
        end
        C_DOT: begin
          hd    <= dsum[DW:1];
          ld    <= {dsum[0], ld[GAIN_BITS-1:1]};
          lo_sh <= lo_sh >> 1;
          hi_sh <= hi_sh >> 1;
          cnt   <= cnt + 1'b1;
          if (cnt == CW'(GAIN_BITS - 1)) begin
            state <= C_SAT;
          end
        end
        C_SAT: begin
          y     <= y_next;
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/stereo_tilt_equalizer.sv
// ----------------------------------------------------------------------------
// Stereo tilt equalizer
// Splits each channel with a one-pole trapezoidal low-pass and mixes the
// low part and the remainder with two gliding gains, saturated to the sample
// width.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: left_in, right_in
//   m_axis   out        tdata: left_out, right_out
//   cfg      in         cfg_index, cfg_data
//
// Each sample pair goes from acceptance to the output register through the
// bit-serial gain glide, then through the bit-serial filter and gain mix
// in each lane.
// A new pair is accepted once the previous one has reached the output
// register; a stalled output holds the finished pair in the lanes.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "stereo_tilt_equalizer_macros.svh"

module stereo_tilt_equalizer #(
  parameter int SAMPLE_BITS = stqe_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = stqe_pkg::COEF_BITS_DEF,
  parameter int DATA_BITS   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stqe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [stqe_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [DATA_BITS-1:0]                 s_axis_tdata,  // left_in, right_in
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [DATA_BITS-1:0]                 m_axis_tdata   // left_out, right_out
);
  import stqe_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GLIDE = 2'd1;
  localparam logic [1:0] S_CHAN  = 2'd2;
  localparam logic [1:0] S_LOAD  = 2'd3;

  logic [1:0]             state;
  logic [COEF_BITS-1:0]   pivot;
  logic [ALPHA_BITS-1:0]  smoothing;
  logic [GAIN_BITS-1:0]   target_low;
  logic [GAIN_BITS-1:0]   target_high;
  logic signed [SAMPLE_BITS-1:0] xl;
  logic signed [SAMPLE_BITS-1:0] xr;
  logic signed [SAMPLE_BITS-1:0] yl;
  logic signed [SAMPLE_BITS-1:0] yr;
  logic [DATA_BITS-1:0]   out_data;

  logic                  in_accept;
  logic                  low_done;
  logic                  high_done;
  logic                  left_done;
  logic                  right_done;
  logic [GAIN_BITS-1:0]  low_gain;
  logic [GAIN_BITS-1:0]  high_gain;
  logic                  out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot       <= COEF_BITS'(PIVOT_RESET);
      smoothing   <= SMOOTHING_RESET;
      target_low  <= TARGET_RESET;
      target_high <= TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PIVOT:       pivot       <= cfg_data[COEF_BITS-1:0];
        REG_SMOOTHING:   smoothing   <= cfg_data[ALPHA_BITS-1:0];
        REG_TARGET_LOW:  target_low  <= cfg_data[GAIN_BITS-1:0];
        REG_TARGET_HIGH: target_high <= cfg_data[GAIN_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      xl <= s_axis_tdata[SAMPLE_BITS-1:0];
      xr <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
  end

  stqe_glide u_glide_low (
    .clk    (clk),
    .rst    (rst),
    .start  (in_accept),
    .alpha  (smoothing),
    .target (target_low),
    .done   (low_done),
    .gain   (low_gain)
  );

  stqe_glide u_glide_high (
    .clk    (clk),
    .rst    (rst),
    .start  (in_accept),
    .alpha  (smoothing),
    .target (target_high),
    .done   (high_done),
    .gain   (high_gain)
  );

  stqe_chan #(
    .SB (SAMPLE_BITS),
    .CB (COEF_BITS)
  ) u_chan_left (
    .clk       (clk),
    .rst       (rst),
    .start     (low_done),
    .x         (xl),
    .g         (pivot),
    .low_gain  (low_gain),
    .high_gain (high_gain),
    .done      (left_done),
    .y         (yl)
  );

  stqe_chan #(
    .SB (SAMPLE_BITS),
    .CB (COEF_BITS)
  ) u_chan_right (
    .clk       (clk),
    .rst       (rst),
    .start     (low_done),
    .x         (xr),
    .g         (pivot),
    .low_gain  (low_gain),
    .high_gain (high_gain),
    .done      (right_done),
    .y         (yr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_LOAD && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_GLIDE;
          end
        end
        S_GLIDE: begin
          if (low_done) begin
            state <= S_CHAN;
          end
        end
        S_CHAN: begin
          if (left_done) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && out_free) begin
      out_data <= DATA_BITS'({yr, yl});
    end
  end

  `STE_ASSERT_NXT(a_accept_starts_glide, clk, rst, in_accept, state == S_GLIDE, "accepted pair did not start the glide")
  `STE_ASSERT_IMP(a_glides_aligned, clk, rst, low_done || high_done, low_done && high_done, "gain glides finished apart")
  `STE_ASSERT_IMP(a_lanes_aligned, clk, rst, left_done || right_done, left_done && right_done, "channel lanes finished apart")
  `STE_ASSERT_NXT(a_load_fills_output, clk, rst, state == S_LOAD && !m_axis_tvalid, m_axis_tvalid, "empty output register was not loaded")

endmodule
